// File: sv/tmpp_pkg.sv
// Package for the trapezoid motion profile planner.
// Types and fixed constants shared by the interfaces, the square-root unit and the top level.
// Depends on nothing.
`default_nettype none
package tmpp_pkg;
  typedef logic signed [31:0] fix_t;    // signed Q16.16 value
  typedef logic [30:0]        mag_t;    // non-negative Q15.16 value
  typedef logic [31:0]        count_t;  // step count

  localparam fix_t   ACC_RESET  = 32'sd65536000;
  localparam mag_t   MAX31      = 31'h7FFF_FFFF;
  localparam count_t MAX32      = 32'hFFFF_FFFF;
  localparam int     ROOT_STEPS = 32;
endpackage
`default_nettype wire

// File: sv/tmpp_ifs.sv
// Valid/ready channel interfaces of the planner: segment in, plan out, acceleration write.
// Depends on tmpp_pkg.
`default_nettype none
interface tmpp_seg_if import tmpp_pkg::*; ();
  logic   valid;
  logic   ready;
  count_t total_steps;
  fix_t   distance;
  fix_t   requested_speed;
  fix_t   entry_speed;
  fix_t   exit_speed;
  modport source (output valid, total_steps, distance, requested_speed, entry_speed,
                  exit_speed, input ready);
  modport sink   (input valid, total_steps, distance, requested_speed, entry_speed,
                  exit_speed, output ready);
endinterface

interface tmpp_plan_if import tmpp_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   plan_valid;
  logic   is_triangular;
  count_t accel_steps;
  count_t cruise_steps;
  count_t decel_steps;
  mag_t   peak_speed;
  mag_t   accel_distance;
  mag_t   cruise_distance;
  mag_t   decel_distance;
  mag_t   start_speed;
  mag_t   end_speed;
  modport source (output valid, plan_valid, is_triangular, accel_steps, cruise_steps,
                  decel_steps, peak_speed, accel_distance, cruise_distance, decel_distance,
                  start_speed, end_speed, input ready);
  modport sink   (input valid, plan_valid, is_triangular, accel_steps, cruise_steps,
                  decel_steps, peak_speed, accel_distance, cruise_distance, decel_distance,
                  start_speed, end_speed, output ready);
endinterface

interface tmpp_cfg_if import tmpp_pkg::*; ();
  logic valid;
  logic ready;
  fix_t acceleration;
  modport source (output valid, acceleration, input ready);
  modport sink   (input valid, acceleration, output ready);
endinterface
`default_nettype wire

// File: sv/tmpp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
// Carries a sideband word in step with the data. Depends on nothing.
`default_nettype none
module tmpp_div_pipe #(
  parameter int DW = 62,
  parameter int VW = 32,
  parameter int QW = 31,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] quotient,
  output logic          out_ovf,
  output logic [SW-1:0] out_side
);
  localparam int W = (DW > VW + QW) ? DW : VW + QW;

  logic [QW:0]   vld;
  logic [QW:0]   ovf;
  logic [W-1:0]  rem  [QW+1];
  logic [VW-1:0] dvs  [QW+1];
  logic [QW-1:0] quo  [QW+1];
  logic [SW-1:0] side [QW+1];

  // Front stage: flag quotients that do not fit in QW bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= W'(dividend);
      dvs[0]  <= divisor;
      quo[0]  <= '0;
      ovf[0]  <= W'(dividend) >= (W'(divisor) << QW);
      side[0] <= in_side;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_bit
    localparam int B = QW - 1 - k;
    logic [W-1:0] shifted;
    logic         take;
    assign shifted = W'(dvs[k]) << B;
    assign take    = rem[k] >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? rem[k] - shifted : rem[k];
        quo[k+1]  <= take ? (quo[k] | (QW'(1) << B)) : quo[k];
        dvs[k+1]  <= dvs[k];
        ovf[k+1]  <= ovf[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quotient  = quo[QW];
  assign out_ovf   = ovf[QW];
  assign out_side  = side[QW];
endmodule
`default_nettype wire

// File: sv/tmpp_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, floor of the root.
// Carries a sideband word in step with the data. Depends on tmpp_pkg.
`default_nettype none
module tmpp_sqrt_pipe import tmpp_pkg::*; #(
  parameter int SW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [62:0]   radicand,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [31:0]   root,
  output logic [SW-1:0] out_side
);
  logic [ROOT_STEPS-1:0] vld;
  logic [63:0]           xr [ROOT_STEPS];
  logic [63:0]           rr [ROOT_STEPS];
  logic [SW-1:0]         sd [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0]   xi;
    logic [63:0]   ri;
    logic [63:0]   trial;
    logic          vi;
    logic [SW-1:0] si;

    if (k == 0) begin : g_first
      assign xi = {1'b0, radicand};
      assign ri = '0;
      assign vi = in_valid;
      assign si = in_side;
    end else begin : g_next
      assign xi = xr[k-1];
      assign ri = rr[k-1];
      assign vi = vld[k-1];
      assign si = sd[k-1];
    end

    assign trial = ri + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (xi >= trial) begin
          xr[k] <= xi - trial;
          rr[k] <= (ri >> 1) + BIT;
        end else begin
          xr[k] <= xi;
          rr[k] <= ri >> 1;
        end
        sd[k] <= si;
      end
    end
  end

  assign out_valid = vld[ROOT_STEPS-1];
  assign root      = rr[ROOT_STEPS-1][31:0];
  assign out_side  = sd[ROOT_STEPS-1];
endmodule
`default_nettype wire

// File: sv/trapezoid_motion_profile_planner_top.sv
// Top level of the trapezoid motion profile planner: stage registers and arithmetic units.
// Depends on tmpp_pkg, tmpp_ifs, tmpp_div_pipe and tmpp_sqrt_pipe.
//
// Usage:
//   cfg  - write channel for the acceleration register (signed Q16.16). Always ready; write
//          it only while no segment is in flight. Reset value is 1000.0 mm/s^2.
//   seg  - one transaction per move segment: steps, distance, requested, entry, exit speed.
//   plan - one transaction per segment, in order: ramp and cruise distances and steps,
//          peak speed, clamped boundary speeds, triangular and valid flags.
// Throughput: one segment per cycle unless the output stalls. Depth is set by the three
// pairs of pipelined dividers (ramp distances, triangular ramp distances, step counts)
// and the 32-step root, one bit a stage.
// Stall: the whole pipeline holds while a plan waits on the output and the receiver is not
// ready; seg.ready follows the same advance signal, so nothing is lost or repeated. While
// the output register is empty the pipeline keeps moving and fills bubbles.
// Reset (synchronous, active high) empties every stage and restores acceleration.
`default_nettype none
module trapezoid_motion_profile_planner_top import tmpp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tmpp_cfg_if.sink    cfg,
  tmpp_seg_if.sink    seg,
  tmpp_plan_if.source plan
);
  logic adv;
  fix_t acc;

  // Advance every stage unless a finished plan is stuck at the output.
  assign adv       = !plan.valid || plan.ready;
  assign seg.ready = adv;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= ACC_RESET;
    end else if (cfg.valid) begin
      acc <= cfg.acceleration;
    end
  end

  // ---------------- stage 1: validity check and speed clamping ----------------
  logic ok_c;
  fix_t ec, xc;
  assign ok_c = (seg.total_steps != '0) && (seg.distance > 0) && (seg.requested_speed > 0)
                && (acc > 0);
  assign ec = (seg.entry_speed < 0) ? '0 :
              (seg.entry_speed > seg.requested_speed) ? seg.requested_speed : seg.entry_speed;
  assign xc = (seg.exit_speed < 0) ? '0 :
              (seg.exit_speed > seg.requested_speed) ? seg.requested_speed : seg.exit_speed;

  logic   s1_vld, s1_ok;
  count_t s1_n;
  mag_t   s1_ud, s1_uv, s1_ue, s1_ux, s1_ua, s1_ss, s1_es;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= seg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ok <= ok_c;
      s1_n  <= seg.total_steps;
      s1_ud <= seg.distance[30:0];
      s1_uv <= seg.requested_speed[30:0];
      s1_ue <= ec[30:0];
      s1_ux <= xc[30:0];
      s1_ua <= acc[30:0];
      // An invalid segment passes the raw boundary speeds through.
      s1_ss <= ok_c ? ec[30:0] : seg.entry_speed[30:0];
      s1_es <= ok_c ? xc[30:0] : seg.exit_speed[30:0];
    end
  end

  // ---------------- stage 2: squares and a*d ----------------
  logic        s2_vld, s2_ok;
  count_t      s2_n;
  mag_t        s2_ud, s2_uv, s2_ss, s2_es;
  logic [61:0] s2_v2, s2_e2, s2_x2, s2_m;
  logic [31:0] s2_two_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ok    <= s1_ok;
      s2_n     <= s1_n;
      s2_ud    <= s1_ud;
      s2_uv    <= s1_uv;
      s2_ss    <= s1_ss;
      s2_es    <= s1_es;
      s2_v2    <= 62'(s1_uv) * 62'(s1_uv);
      s2_e2    <= 62'(s1_ue) * 62'(s1_ue);
      s2_x2    <= 62'(s1_ux) * 62'(s1_ux);
      s2_m     <= 62'(s1_ua) * 62'(s1_ud);
      s2_two_a <= {s1_ua, 1'b0};
    end
  end

  // ---------------- stage 3: ramp numerators and squared triangular peak ----------------
  logic [62:0] hsum, p0, p1, p2;
  assign hsum = 63'(s2_e2) + 63'(s2_x2);
  assign p0   = 63'(s2_m) + 63'(hsum[62:1]);
  assign p1   = (p0 < 63'(s2_e2)) ? 63'(s2_e2) : p0;
  assign p2   = (p1 < 63'(s2_x2)) ? 63'(s2_x2) : p1;

  logic        s3_vld, s3_ok;
  count_t      s3_n;
  mag_t        s3_ud, s3_uv, s3_ss, s3_es;
  logic [61:0] s3_na, s3_nd, s3_e2, s3_x2;
  logic [62:0] s3_psq;
  logic [31:0] s3_two_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ok    <= s2_ok;
      s3_n     <= s2_n;
      s3_ud    <= s2_ud;
      s3_uv    <= s2_uv;
      s3_ss    <= s2_ss;
      s3_es    <= s2_es;
      s3_na    <= (s2_v2 > s2_e2) ? s2_v2 - s2_e2 : '0;
      s3_nd    <= (s2_v2 > s2_x2) ? s2_v2 - s2_x2 : '0;
      s3_e2    <= s2_e2;
      s3_x2    <= s2_x2;
      s3_psq   <= p2;
      s3_two_a <= s2_two_a;
    end
  end

  // ---------------- block 1: ramp divisions and root, in lockstep ----------------
  logic        d1a_vld, d1d_vld, r1_vld, d1a_ovf, d1d_ovf;
  logic [30:0] d1a_q, d1d_q;
  logic [31:0] r1_root;
  logic        m1_ok;
  count_t      m1_n;
  mag_t        m1_ud, m1_uv, m1_ss, m1_es;
  logic [61:0] m1_e2, m1_x2;
  logic [31:0] m1_two_a;

  tmpp_div_pipe #(.DW(62), .VW(32), .QW(31), .SW(157)) u_div1a (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s3_vld), .dividend(s3_na), .divisor(s3_two_a),
    .in_side({s3_ok, s3_n, s3_ud, s3_uv, s3_ss, s3_es}),
    .out_valid(d1a_vld), .quotient(d1a_q), .out_ovf(d1a_ovf),
    .out_side({m1_ok, m1_n, m1_ud, m1_uv, m1_ss, m1_es})
  );

  tmpp_div_pipe #(.DW(62), .VW(32), .QW(31), .SW(124)) u_div1d (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s3_vld), .dividend(s3_nd), .divisor(s3_two_a),
    .in_side({s3_e2, s3_x2}),
    .out_valid(d1d_vld), .quotient(d1d_q), .out_ovf(d1d_ovf), .out_side({m1_e2, m1_x2})
  );

  tmpp_sqrt_pipe #(.SW(32)) u_sqrt (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s3_vld), .radicand(s3_psq), .in_side(s3_two_a),
    .out_valid(r1_vld), .root(r1_root), .out_side(m1_two_a)
  );

  // ---------------- stage 5: trapezoid or triangle ----------------
  logic tri_c;
  // A ramp that overflows 31 bits always exceeds the distance.
  assign tri_c = d1a_ovf || d1d_ovf || (({1'b0, d1a_q} + {1'b0, d1d_q}) > {1'b0, m1_ud});

  logic        s5_vld, s5_ok, s5_tri;
  count_t      s5_n;
  mag_t        s5_ud, s5_ss, s5_es, s5_ad0, s5_dd0, s5_peak;
  logic [61:0] s5_e2, s5_x2;
  logic [31:0] s5_two_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (adv) begin
      s5_vld <= d1a_vld && d1d_vld && r1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ok    <= m1_ok;
      s5_tri   <= tri_c;
      s5_n     <= m1_n;
      s5_ud    <= m1_ud;
      s5_ss    <= m1_ss;
      s5_es    <= m1_es;
      s5_ad0   <= d1a_q;
      s5_dd0   <= d1d_q;
      // A trapezoid cruises at the requested speed; a triangle peaks at the capped root.
      s5_peak  <= (!tri_c || (r1_root > {1'b0, m1_uv})) ? m1_uv : r1_root[30:0];
      s5_e2    <= m1_e2;
      s5_x2    <= m1_x2;
      s5_two_a <= m1_two_a;
    end
  end

  // ---------------- stage 6: square of the peak ----------------
  logic        s6_vld, s6_ok, s6_tri;
  count_t      s6_n;
  mag_t        s6_ud, s6_ss, s6_es, s6_ad0, s6_dd0, s6_peak;
  logic [61:0] s6_e2, s6_x2, s6_pk2;
  logic [31:0] s6_two_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (adv) begin
      s6_vld <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_ok    <= s5_ok;
      s6_tri   <= s5_tri;
      s6_n     <= s5_n;
      s6_ud    <= s5_ud;
      s6_ss    <= s5_ss;
      s6_es    <= s5_es;
      s6_ad0   <= s5_ad0;
      s6_dd0   <= s5_dd0;
      s6_peak  <= s5_peak;
      s6_e2    <= s5_e2;
      s6_x2    <= s5_x2;
      s6_two_a <= s5_two_a;
      s6_pk2   <= 62'(s5_peak) * 62'(s5_peak);
    end
  end

  // ---------------- stage 7: triangular ramp numerators ----------------
  logic        s7_vld, s7_ok, s7_tri;
  count_t      s7_n;
  mag_t        s7_ud, s7_ss, s7_es, s7_ad0, s7_dd0, s7_peak;
  logic [61:0] s7_na, s7_nd;
  logic [31:0] s7_two_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else if (adv) begin
      s7_vld <= s6_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_ok    <= s6_ok;
      s7_tri   <= s6_tri;
      s7_n     <= s6_n;
      s7_ud    <= s6_ud;
      s7_ss    <= s6_ss;
      s7_es    <= s6_es;
      s7_ad0   <= s6_ad0;
      s7_dd0   <= s6_dd0;
      s7_peak  <= s6_peak;
      s7_two_a <= s6_two_a;
      s7_na    <= (s6_pk2 > s6_e2) ? s6_pk2 - s6_e2 : '0;
      s7_nd    <= (s6_pk2 > s6_x2) ? s6_pk2 - s6_x2 : '0;
    end
  end

  // ---------------- block 2: triangular ramp divisions ----------------
  logic        d2a_vld, d2d_vld, d2a_ovf, d2d_ovf;
  logic [30:0] d2a_q, d2d_q;
  logic        m2_ok, m2_tri;
  count_t      m2_n;
  mag_t        m2_ud, m2_ss, m2_es, m2_peak, m2_ad0, m2_dd0;

  tmpp_div_pipe #(.DW(62), .VW(32), .QW(31), .SW(158)) u_div2a (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s7_vld), .dividend(s7_na), .divisor(s7_two_a),
    .in_side({s7_ok, s7_tri, s7_n, s7_ud, s7_ss, s7_es, s7_peak}),
    .out_valid(d2a_vld), .quotient(d2a_q), .out_ovf(d2a_ovf),
    .out_side({m2_ok, m2_tri, m2_n, m2_ud, m2_ss, m2_es, m2_peak})
  );

  tmpp_div_pipe #(.DW(62), .VW(32), .QW(31), .SW(62)) u_div2d (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s7_vld), .dividend(s7_nd), .divisor(s7_two_a),
    .in_side({s7_ad0, s7_dd0}),
    .out_valid(d2d_vld), .quotient(d2d_q), .out_ovf(d2d_ovf), .out_side({m2_ad0, m2_dd0})
  );

  // ---------------- stage 8: select ramp and cruise distances ----------------
  logic   s8_vld, s8_ok, s8_tri;
  count_t s8_n;
  mag_t   s8_ud, s8_ss, s8_es, s8_peak, s8_ad, s8_dd, s8_cd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else if (adv) begin
      s8_vld <= d2a_vld && d2d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_ok   <= m2_ok;
      s8_tri  <= m2_tri;
      s8_n    <= m2_n;
      s8_ud   <= m2_ud;
      s8_ss   <= m2_ss;
      s8_es   <= m2_es;
      s8_peak <= m2_peak;
      // Saturate the triangular ramps; trapezoid ramps already fit the distance.
      s8_ad   <= m2_tri ? (d2a_ovf ? MAX31 : d2a_q) : m2_ad0;
      s8_dd   <= m2_tri ? (d2d_ovf ? MAX31 : d2d_q) : m2_dd0;
      s8_cd   <= m2_tri ? '0 : m2_ud - m2_ad0 - m2_dd0;
    end
  end

  // ---------------- stage 9: ramp distance times step count ----------------
  logic        s9_vld, s9_ok, s9_tri;
  count_t      s9_n;
  mag_t        s9_ud, s9_ss, s9_es, s9_peak, s9_ad, s9_dd, s9_cd;
  logic [62:0] s9_pa, s9_pd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_vld <= 1'b0;
    end else if (adv) begin
      s9_vld <= s8_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_ok   <= s8_ok;
      s9_tri  <= s8_tri;
      s9_n    <= s8_n;
      s9_ud   <= s8_ud;
      s9_ss   <= s8_ss;
      s9_es   <= s8_es;
      s9_peak <= s8_peak;
      s9_ad   <= s8_ad;
      s9_dd   <= s8_dd;
      s9_cd   <= s8_cd;
      s9_pa   <= 63'(s8_ad) * 63'(s8_n);
      s9_pd   <= 63'(s8_dd) * 63'(s8_n);
    end
  end

  // ---------------- block 3: step count divisions ----------------
  logic        d3a_vld, d3d_vld, d3a_ovf, d3d_ovf;
  count_t      d3a_q, d3d_q;
  logic        m3_ok, m3_tri;
  count_t      m3_n;
  mag_t        m3_ss, m3_es, m3_peak, m3_ad, m3_dd, m3_cd;

  tmpp_div_pipe #(.DW(63), .VW(31), .QW(32), .SW(127)) u_div3a (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s9_vld), .dividend(s9_pa), .divisor(s9_ud),
    .in_side({s9_ok, s9_tri, s9_n, s9_peak, s9_ss, s9_es}),
    .out_valid(d3a_vld), .quotient(d3a_q), .out_ovf(d3a_ovf),
    .out_side({m3_ok, m3_tri, m3_n, m3_peak, m3_ss, m3_es})
  );

  tmpp_div_pipe #(.DW(63), .VW(31), .QW(32), .SW(93)) u_div3d (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s9_vld), .dividend(s9_pd), .divisor(s9_ud),
    .in_side({s9_ad, s9_dd, s9_cd}),
    .out_valid(d3d_vld), .quotient(d3d_q), .out_ovf(d3d_ovf),
    .out_side({m3_ad, m3_dd, m3_cd})
  );

  // ---------------- output register: step split and invalid masking ----------------
  count_t      as0, ds0, as_f, ds_f, cs_f;
  logic [32:0] ssum;
  logic        split;

  assign as0   = d3a_ovf ? MAX32 : d3a_q;
  assign ds0   = d3d_ovf ? MAX32 : d3d_q;
  assign ssum  = {1'b0, as0} + {1'b0, ds0};
  // Ramps claim more steps than the move has: halve the count between them.
  assign split = ssum > {1'b0, m3_n};
  assign as_f  = split ? (m3_n >> 1) : as0;
  assign ds_f  = split ? (m3_n - (m3_n >> 1)) : ds0;
  assign cs_f  = split ? '0 : m3_n - as0 - ds0;

  always_ff @(posedge clk) begin
    if (rst) begin
      plan.valid <= 1'b0;
    end else if (adv) begin
      plan.valid <= d3a_vld && d3d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      plan.plan_valid      <= m3_ok;
      plan.is_triangular   <= m3_ok && m3_tri;
      plan.accel_steps     <= m3_ok ? as_f : '0;
      plan.cruise_steps    <= m3_ok ? cs_f : '0;
      plan.decel_steps     <= m3_ok ? ds_f : '0;
      plan.peak_speed      <= m3_ok ? m3_peak : '0;
      plan.accel_distance  <= m3_ok ? m3_ad : '0;
      plan.cruise_distance <= m3_ok ? m3_cd : '0;
      plan.decel_distance  <= m3_ok ? m3_dd : '0;
      plan.start_speed     <= m3_ss;
      plan.end_speed       <= m3_es;
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !plan.valid)
    else $error("plan valid right after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (plan.valid && !plan.plan_valid) |->
      (plan.accel_steps == '0 && plan.cruise_steps == '0 && plan.decel_steps == '0 &&
       plan.peak_speed == '0 && plan.accel_distance == '0 && plan.decel_distance == '0 &&
       !plan.is_triangular))
    else $error("invalid plan carries nonzero results");

  a_tri_no_cruise: assert property (@(posedge clk) disable iff (rst)
    (plan.valid && plan.is_triangular) |-> plan.cruise_distance == '0)
    else $error("triangular plan with cruise distance");

  a_peak_bounds: assert property (@(posedge clk) disable iff (rst)
    (plan.valid && plan.plan_valid) |->
      (plan.peak_speed >= plan.start_speed && plan.peak_speed >= plan.end_speed))
    else $error("peak speed below a boundary speed");
`endif
endmodule
`default_nettype wire
